FILE: sv/lex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lex_pkg
// shared types and constants of the lexer with identifier interning
// ----------------------------------------------------------------------------
package lex_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 31;
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   typedef enum logic [1:0] {
      TAG_CONST   = 2'd0,
      TAG_IDENT   = 2'd1,
      TAG_SIGN    = 2'd2,
      TAG_UNKNOWN = 2'd3
   } tag_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_CONST = 2'd1,
      MODE_IDENT = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_SEARCH = 3'd1,
      ST_EMIT1  = 3'd2,
      ST_EMIT2  = 3'd3
   } state_type;

   // search wave sent down the cell row
   typedef struct packed {
      logic valid;
      logic found;
   } wave_type;

   localparam logic [CHAR_W-1:0] CH_NL = 8'd10;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   // sign index, or 7 for none
   function automatic logic [2:0] sign_index(input logic [CHAR_W-1:0] c);
      logic [2:0] r;
      case (c)
         8'h2B: r = 3'd0;
         8'h2D: r = 3'd1;
         8'h2A: r = 3'd2;
         8'h2F: r = 3'd3;
         8'h28: r = 3'd4;
         8'h29: r = 3'd5;
         default: r = 3'd7;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/lex_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lex_cell
// one table entry: stored identifier, compared against the held one
// ----------------------------------------------------------------------------
module lex_cell #(
   parameter int unsigned ID_CHARS = 16,
   parameter int unsigned LEN_W    = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [ID_CHARS*8-1:0]         wr_chars,
   input  logic [LEN_W-1:0]              wr_len,
   input  logic [ID_CHARS*8-1:0]         key_chars,
   input  logic [LEN_W-1:0]              key_len,
   input  logic                          in_use,
   input  lex_pkg::wave_type             wave_in,
   output lex_pkg::wave_type             wave_out,
   output logic                          hit
);
   import lex_pkg::*;

   logic [ID_CHARS*8-1:0] chars_ff;
   logic [LEN_W-1:0]      len_ff;
   logic                  match;
   wave_type              wave_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         chars_ff <= wr_chars;
         len_ff   <= wr_len;
      end
   end

   // characters beyond the key length hold zeros in both, so compare whole
   assign match = in_use && (len_ff == key_len) && (chars_ff == key_chars);
   assign hit   = match;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= '0;
      end else begin
         wave_ff.valid <= wave_in.valid;
         wave_ff.found <= wave_in.found | match;
      end
   end
   assign wave_out = wave_ff;
endmodule

FILE: sv/lexer_with_identifier_interning_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexer_with_identifier_interning_unit
// character lexer with an identifier table built as a row of compare cells
// ----------------------------------------------------------------------------
// One character word per accept. Digits and letters that extend a token and
// spaces need no extra state. A character that ends an identifier starts a
// search: every cell compares the identifier at once and the hit wave ripples
// one cell a cycle to the end of the row. A sign or unknown character that ends
// a token gives its own word from a second state after the token's word. A
// newline empties the table at once by clearing the entry count.
module lexer_with_identifier_interning_unit #(
   parameter int unsigned ID_CHARS    = 16,
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_ch,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_tag,
   output logic [30:0]                      rsp_token_value,
   output logic                             rsp_error_flag,
   output logic                             rsp_last
);
   import lex_pkg::*;

   localparam int unsigned LEN_W = $clog2(ID_CHARS + 1);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [VALUE_W-1:0]    acc_ff, acc_in;
   logic                  sat_ff, sat_in;
   logic [ID_CHARS*8-1:0] id_ff, id_in;
   logic [LEN_W-1:0]      idlen_ff, idlen_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [7:0]            ch_ff, ch_in;
   logic                  second_ff, second_in;
   logic [1:0]            tag2_ff, tag2_in;
   logic [VALUE_W-1:0]    val2_ff, val2_in;
   logic [1:0]            otag_ff, otag_in;
   logic [VALUE_W-1:0]    oval_ff, oval_in;
   logic                  oerr_ff, oerr_in;
   logic                  olast_ff, olast_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic [IDX_W-1:0]      hit_idx;
   logic                  start;
   logic                  wr_new;

   wave_type              wave [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] hits;

   assign wave[0].valid = start;
   assign wave[0].found = 1'b0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      lex_cell #(.ID_CHARS(ID_CHARS), .LEN_W(LEN_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (wr_new && (count_ff == CNT_W'(i))),
         .wr_chars  (id_ff),
         .wr_len    (idlen_ff),
         .key_chars (id_ff),
         .key_len   (idlen_ff),
         .in_use    (count_ff > CNT_W'(i)),
         .wave_in   (wave[i]),
         .wave_out  (wave[i+1]),
         .hit       (hits[i])
      );
   end

   // at most one entry matches, so or the indexes of the hits
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (hits[i]) hit_idx = hit_idx | IDX_W'(i);
      end
   end

   logic [VALUE_W-1:0] hit_idx_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_SEARCH && step_ff == '0) hit_idx_ff <= VALUE_W'(hit_idx);
   end

   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE) || !out_free;

   logic [34:0] mul10;
   logic [2:0]  sidx;
   logic        acc_fire;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      id_in        = id_ff;
      idlen_in     = idlen_ff;
      count_in     = count_ff;
      ch_in        = ch_ff;
      second_in    = second_ff;
      tag2_in      = tag2_ff;
      val2_in      = val2_ff;
      otag_in      = otag_ff;
      oval_in      = oval_ff;
      oerr_in      = oerr_ff;
      olast_in     = olast_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      start        = 1'b0;
      wr_new       = 1'b0;
      acc_fire     = req_valid && !req_stall;
      mul10        = {4'd0, acc_ff} * 35'd10 + 35'(req_ch - 8'h30);
      sidx         = sign_index(req_ch);

      case (state_ff)
         ST_IDLE: begin
            if (acc_fire) begin
               ch_in = req_ch;
               if (mode_ff == MODE_CONST && is_digit(req_ch)) begin
                  if (mul10 > 35'(VALUE_MAX)) begin
                     acc_in = VALUE_MAX;
                     sat_in = 1'b1;
                  end else begin
                     acc_in = mul10[VALUE_W-1:0];
                  end
               end else if (mode_ff == MODE_IDENT
                            && (is_letter(req_ch) || is_digit(req_ch))
                            && idlen_ff < LEN_W'(ID_CHARS)) begin
                  id_in[idlen_ff[LEN_W-1:0]*8 +: 8] = req_ch;
                  idlen_in = idlen_ff + 1'b1;
               end else begin
                  // second result from the ending character, if any
                  second_in = !(is_digit(req_ch) || is_letter(req_ch) || is_space(req_ch));
                  tag2_in   = (sidx != 3'd7) ? TAG_SIGN : TAG_UNKNOWN;
                  val2_in   = (sidx != 3'd7) ? VALUE_W'(sidx) : VALUE_W'(req_ch);
                  if (mode_ff == MODE_CONST) begin
                     otag_in      = TAG_CONST;
                     oval_in      = acc_ff;
                     oerr_in      = sat_ff;
                     olast_in     = !second_in;
                     rsp_valid_in = 1'b1;
                     state_in     = second_in ? ST_EMIT2 : ST_IDLE;
                  end else if (mode_ff == MODE_IDENT) begin
                     start    = 1'b1;
                     step_in  = '0;
                     state_in = ST_SEARCH;
                  end else if (second_in) begin
                     otag_in      = tag2_in;
                     oval_in      = val2_in;
                     oerr_in      = 1'b0;
                     olast_in     = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  // the new token opens now; identifier chars wait for search
                  if (mode_ff != MODE_IDENT) begin
                     if (is_digit(req_ch)) begin
                        mode_in = MODE_CONST;
                        acc_in  = VALUE_W'(req_ch - 8'h30);
                        sat_in  = 1'b0;
                     end else if (is_letter(req_ch)) begin
                        mode_in  = MODE_IDENT;
                        id_in    = '0;
                        id_in[7:0] = req_ch;
                        idlen_in = LEN_W'(1);
                     end else begin
                        mode_in = MODE_IDLE;
                        if (req_ch == CH_NL) count_in = '0;
                     end
                  end
               end
            end
         end
         ST_SEARCH: begin
            step_in = step_ff + 1'b1;
            if (wave[TABLE_DEPTH].valid && out_free) begin
               otag_in  = TAG_IDENT;
               olast_in = !second_ff;
               if (wave[TABLE_DEPTH].found) begin
                  oval_in = hit_idx_ff;
                  oerr_in = 1'b0;
               end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                  oval_in = VALUE_W'(TABLE_DEPTH);
                  oerr_in = 1'b1;
               end else begin
                  wr_new   = 1'b1;
                  oval_in  = VALUE_W'(count_ff);
                  oerr_in  = 1'b0;
                  count_in = count_ff + 1'b1;
               end
               rsp_valid_in = 1'b1;
               state_in     = second_ff ? ST_EMIT2 : ST_IDLE;
               // open the token started by the ending character
               if (is_digit(ch_ff)) begin
                  mode_in = MODE_CONST;
                  acc_in  = VALUE_W'(ch_ff - 8'h30);
                  sat_in  = 1'b0;
               end else if (is_letter(ch_ff)) begin
                  mode_in  = MODE_IDENT;
                  id_in    = '0;
                  id_in[7:0] = ch_ff;
                  idlen_in = LEN_W'(1);
               end else begin
                  mode_in = MODE_IDLE;
                  if (ch_ff == CH_NL) count_in = '0;
               end
            end
         end
         ST_EMIT2: begin
            if (out_free) begin
               otag_in      = tag2_ff;
               oval_in      = val2_ff;
               oerr_in      = 1'b0;
               olast_in     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idlen_ff     <= '0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         id_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         idlen_ff     <= idlen_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         id_ff        <= id_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff     <= ch_in;
      second_ff <= second_in;
      tag2_ff   <= tag2_in;
      val2_ff   <= val2_in;
      otag_ff   <= otag_in;
      oval_ff   <= oval_in;
      oerr_ff   <= oerr_in;
      olast_ff  <= olast_in;
      step_ff   <= step_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tag         = otag_ff;
   assign rsp_token_value = oval_ff;
   assign rsp_error_flag  = oerr_ff;
   assign rsp_last        = olast_ff;
endmodule

FILE: sv/lex_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lex_assertions
// port-level checks of the lexer
// ----------------------------------------------------------------------------
module lex_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_tag,
   input logic [30:0] rsp_token_value,
   input logic        rsp_error_flag,
   input logic        rsp_last
);
   import lex_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_value) && $stable(rsp_tag))
      else $error("stalled word changed");

   a_sign_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tag == TAG_SIGN || rsp_tag == TAG_UNKNOWN) |-> !rsp_error_flag)
      else $error("error flag on sign word");

   a_sign_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tag == TAG_SIGN |-> rsp_last && rsp_token_value < 31'd6)
      else $error("bad sign word");

   a_stall_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");
endmodule

bind lexer_with_identifier_interning_unit lex_assertions u_lex_assertions (.*);

FILE: bench/lex_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lex_checker
// predicts the token words of the lexer and compares them with the outputs
// ----------------------------------------------------------------------------
// Every accepted character is run through a behavioral lexer with its own
// identifier table; the token words it gives are queued and compared, field
// by field, with the words the block hands out.
module lex_checker
   import lex_pkg::*;
#(
   parameter int unsigned ID_CHARS    = 16,
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_tag,
   input  logic [30:0] rsp_token_value,
   input  logic        rsp_error_flag,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      tag_type     tag;
      logic [30:0] value;
      logic        err;
      logic        last;
   } token_word;

   token_word tokens_due[$];

   mode_type    lex_mode;
   logic [31:0] num_acc;
   logic        num_sat;
   logic [7:0]  name_buf [ID_CHARS];
   int          name_len;
   logic [7:0]  sym_chars [TABLE_DEPTH][ID_CHARS];
   int          sym_len [TABLE_DEPTH];
   int          sym_count;

   assign pending = tokens_due.size();

   function automatic logic dig(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic let_c(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   task automatic intern_name(output logic [30:0] idx, output logic err);
      logic same;
      for (int e = 0; e < sym_count; e++) begin
         if (sym_len[e] == name_len) begin
            same = 1'b1;
            for (int i = 0; i < name_len; i++)
               if (sym_chars[e][i] != name_buf[i]) same = 1'b0;
            if (same) begin
               idx = 31'(e);
               err = 1'b0;
               return;
            end
         end
      end
      if (sym_count >= TABLE_DEPTH) begin
         idx = 31'(TABLE_DEPTH);
         err = 1'b1;
         return;
      end
      for (int i = 0; i < name_len; i++) sym_chars[sym_count][i] = name_buf[i];
      sym_len[sym_count] = name_len;
      idx = 31'(sym_count);
      err = 1'b0;
      sym_count++;
   endtask

   task automatic lex_char(input logic [7:0] c);
      token_word w;
      token_word words[$];
      logic [63:0] nx;
      logic [2:0] si;
      if (lex_mode == MODE_CONST && dig(c)) begin
         nx = {32'd0, num_acc} * 10 + (c - "0");
         if (nx > 64'h7FFF_FFFF) begin
            num_acc = 32'h7FFF_FFFF;
            num_sat = 1'b1;
         end else begin
            num_acc = nx[31:0];
         end
         return;
      end
      if (lex_mode == MODE_IDENT && (let_c(c) || dig(c)) && name_len < ID_CHARS) begin
         name_buf[name_len] = c;
         name_len++;
         return;
      end
      // close the open token
      if (lex_mode == MODE_CONST) begin
         w = '{TAG_CONST, num_acc[30:0], num_sat, 1'b0};
         words.push_back(w);
      end else if (lex_mode == MODE_IDENT) begin
         w.tag = TAG_IDENT;
         w.last = 1'b0;
         intern_name(w.value, w.err);
         words.push_back(w);
      end
      lex_mode = MODE_IDLE;
      if (dig(c)) begin
         lex_mode = MODE_CONST;
         num_acc = 32'(c - "0");
         num_sat = 1'b0;
      end else if (let_c(c)) begin
         lex_mode = MODE_IDENT;
         name_buf[0] = c;
         name_len = 1;
      end else if (c == CH_NL) begin
         sym_count = 0;
      end else if (!(c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) begin
         case (c)
            "+": si = 3'd0;
            "-": si = 3'd1;
            "*": si = 3'd2;
            "/": si = 3'd3;
            "(": si = 3'd4;
            ")": si = 3'd5;
            default: si = 3'd7;
         endcase
         if (si != 3'd7) w = '{TAG_SIGN, 31'(si), 1'b0, 1'b0};
         else w = '{TAG_UNKNOWN, 31'(c), 1'b0, 1'b0};
         words.push_back(w);
      end
      if (words.size() > 0) words[words.size()-1].last = 1'b1;
      foreach (words[i]) tokens_due.push_back(words[i]);
   endtask

   always @(posedge clock) begin
      token_word exp_w;
      if (reset) begin
         lex_mode <= MODE_IDLE;
         num_acc <= '0;
         num_sat <= 1'b0;
         name_len <= 0;
         sym_count <= 0;
         fail_count <= 0;
         tokens_due.delete();
      end else begin
         // result side first: a word never comes out on the edge its char goes in
         if (rsp_valid && !rsp_stall) begin
            if (tokens_due.size() == 0) begin
               $error("unexpected token word tag=%0d value=%0d", rsp_tag, rsp_token_value);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = tokens_due.pop_front();
               if (rsp_tag != exp_w.tag || rsp_token_value != exp_w.value ||
                   rsp_error_flag != exp_w.err || rsp_last != exp_w.last)
                  fail_count <= fail_count + 1;
               if (rsp_tag != exp_w.tag)
                  $error("tag: expected %0d, got %0d", exp_w.tag, rsp_tag);
               if (rsp_token_value != exp_w.value)
                  $error("token_value: expected %0d, got %0d", exp_w.value, rsp_token_value);
               if (rsp_error_flag != exp_w.err)
                  $error("error_flag: expected %0d, got %0d", exp_w.err, rsp_error_flag);
               if (rsp_last != exp_w.last)
                  $error("last: expected %0d, got %0d", exp_w.last, rsp_last);
            end
         end
         if (req_valid && !req_stall) lex_char(req_ch);
      end
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the lexer with identifier interning
// ----------------------------------------------------------------------------
// Directed characters cover constants with overflow, every sign, unknown bytes,
// long identifiers and a full table; then random lines of expressions with
// noise, under several idle and stall patterns.
module tb_top;
   import lex_pkg::*;

   localparam int unsigned ID_CHARS    = 16;
   localparam int unsigned TABLE_DEPTH = 64;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_ch;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_tag;
   logic [30:0] rsp_token_value;
   logic        rsp_error_flag;
   logic        rsp_last;
   int          fail_count;
   int          pending;
   int          send_idle_pct;
   int          stall_pct;
   int          char_count;

   lexer_with_identifier_interning_unit #(
      .ID_CHARS(ID_CHARS), .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (.*);

   lex_checker #(.ID_CHARS(ID_CHARS), .TABLE_DEPTH(TABLE_DEPTH)) u_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      char_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_letter();
      return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
   endfunction

   // one random line of expression-like text with some noise
   task automatic send_line();
      int n;
      int k;
      string signs;
      signs = "+-*/()";
      n = $urandom_range(12, 2);
      for (int t = 0; t < n; t++) begin
         k = $urandom_range(9);
         if (k < 4) begin
            // short names from a small pool so lookups hit
            send_char(8'("a" + $urandom_range(3)));
            if ($urandom_range(1)) send_char(8'("0" + $urandom_range(2)));
         end else if (k < 5) begin
            repeat ($urandom_range(20, 1)) send_char($urandom_range(1) ? rand_letter()
                                                    : 8'("0" + $urandom_range(9)));
         end else if (k < 7) begin
            repeat ($urandom_range(12, 1)) send_char(8'("0" + $urandom_range(9)));
         end else if (k < 9) begin
            send_char(signs[$urandom_range(5)]);
         end else begin
            send_char(8'($urandom_range(255)));
         end
         if ($urandom_range(2) == 0) send_char(" ");
      end
      send_char(CH_NL);
   endtask

   initial begin
      int sent;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ch = 8'd0;
      send_idle_pct = 0;
      stall_pct = 0;
      char_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: overflow, all signs, extremes of the byte, long names
      send_text("0 2147483647 2147483648 99999999999+-*/()");
      send_char(8'd0);
      send_char(8'd255);
      send_char(8'd9);
      send_text("abcdefghijklmnopq7 Z9");
      send_char(CH_NL);
      drain();
      // fill the table past its depth
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
         send_char(8'("A" + i / 26));
         send_char(8'("a" + i % 26));
         send_char(" ");
      end
      send_text("Aa x");
      send_char(CH_NL);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 75 : 31) : 0;
         stall_pct = (ph == 2) ? 75 : (ph == 3 ? 31 : 0);
         sent = char_count;
         while (char_count - sent < 390) begin
            send_line();
         end
         drain();
      end
      send_idle_pct = 0;
      stall_pct = 0;
      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/lex_pkg.sv
sv/lex_cell.sv
sv/lexer_with_identifier_interning_unit.sv
sv/lex_checker.sv
bench/lex_checker.sv
bench/tb_top.sv
